[sv/sccp_pkg.sv]
// Package: codes, constants and the control program of the supercap charge and path controller.
package sccp_pkg;

  // Default width of the voltage field
  localparam int VOLTAGE_BITS_DEF = 16;

  // Register file
  localparam int CFG_W   = 15;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_VOLTAGE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AVAIL_VOLTAGE = 2'd1;
  localparam logic [CFG_W-1:0] MIN_VOLTAGE_RST   = 15'd8000;
  localparam logic [CFG_W-1:0] AVAIL_VOLTAGE_RST = 15'd12000;

  // Capacitor mode codes
  localparam logic [1:0] MODE_OFF = 2'd0;
  localparam logic [1:0] MODE_ON  = 2'd1;
  localparam logic [1:0] MODE_ERR = 2'd2;

  // Request codes (charge and path)
  localparam logic [1:0] CHG_STOP   = 2'd0;
  localparam logic [1:0] CHG_RUN    = 2'd1;
  localparam logic [1:0] PATH_CAP   = 2'd0;
  localparam logic [1:0] PATH_REF   = 2'd1;

  // Current setpoints in mA, voltage breakpoints in mV
  localparam int CUR_W = 13;
  localparam logic [CUR_W-1:0] CUR_LOW_V  = 13'd4000;
  localparam logic [CUR_W-1:0] CUR_MID_V  = 13'd3000;
  localparam logic [CUR_W-1:0] CUR_MAX    = 13'd5000;
  localparam int V_LOW_MV  = 7000;
  localparam int V_MID_MV  = 12000;
  localparam int V_HIGH_MV = 26500;
  localparam int DEAD_MA   = 100;

  // Divider: numerator 0.7 W/V scaled to mA, 14 quotient bits
  localparam int NUM_W = 28;
  localparam int Q_W   = 14;
  localparam int DEN_W = 15;
  localparam logic [19:0] PWR_K = 20'd700000;

  // Program counter
  localparam int PC_W = 3;
  localparam logic [PC_W-1:0] PC_ACCEPT   = 3'd0;
  localparam logic [PC_W-1:0] PC_EVAL     = 3'd1;
  localparam logic [PC_W-1:0] PC_DIV_INIT = 3'd2;
  localparam logic [PC_W-1:0] PC_DIV_STEP = 3'd3;
  localparam logic [PC_W-1:0] PC_DIV_FIN  = 3'd4;
  localparam logic [PC_W-1:0] PC_EMIT     = 3'd5;

  // Branch conditions
  typedef enum logic [2:0] {
    C_NEVER    = 3'd0,
    C_NO_IN    = 3'd1,
    C_NO_DIV   = 3'd2,
    C_DIV_MORE = 3'd3,
    C_OUT_BUSY = 3'd4,
    C_ALWAYS   = 3'd5
  } cond_t;

  // One control word
  typedef struct packed {
    logic            latch;
    logic            upd_mode;
    logic            upd_chg;
    logic            div_init;
    logic            div_step;
    logic            div_fin;
    logic            emit;
    cond_t           wait_c;
    cond_t           jmp_c;
    logic [PC_W-1:0] target;
  } ctrl_t;

  // Control program ROM
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    w = '{latch: 1'b0, upd_mode: 1'b0, upd_chg: 1'b0, div_init: 1'b0, div_step: 1'b0,
          div_fin: 1'b0, emit: 1'b0, wait_c: C_NEVER, jmp_c: C_ALWAYS, target: PC_ACCEPT};
    unique case (pc)
      PC_ACCEPT: begin
        w.latch  = 1'b1;
        w.wait_c = C_NO_IN;
        w.jmp_c  = C_NEVER;
      end
      PC_EVAL: begin
        w.upd_mode = 1'b1;
        w.upd_chg  = 1'b1;
        w.jmp_c    = C_NO_DIV;
        w.target   = PC_EMIT;
      end
      PC_DIV_INIT: begin
        w.div_init = 1'b1;
        w.jmp_c    = C_NEVER;
      end
      PC_DIV_STEP: begin
        w.div_step = 1'b1;
        w.jmp_c    = C_DIV_MORE;
        w.target   = PC_DIV_STEP;
      end
      PC_DIV_FIN: begin
        w.div_fin = 1'b1;
        w.jmp_c   = C_NEVER;
      end
      PC_EMIT: begin
        w.emit   = 1'b1;
        w.wait_c = C_OUT_BUSY;
        w.jmp_c  = C_ALWAYS;
        w.target = PC_ACCEPT;
      end
      default: begin
        w.jmp_c  = C_ALWAYS;
        w.target = PC_ACCEPT;
      end
    endcase
    return w;
  endfunction

endpackage

[sv/sccp_if.sv]
// Interfaces: input tick channel and result channel of the supercap controller.
interface sccp_in_if #(
  parameter int VOLTAGE_BITS = sccp_pkg::VOLTAGE_BITS_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [VOLTAGE_BITS-1:0] cap_voltage_mv;
  logic [1:0]                     charge_request;
  logic [7:0]                     referee_power_w;
  logic [1:0]                     path_request;

  modport source (output valid, cap_voltage_mv, charge_request, referee_power_w,
                  path_request, input ready);
  modport sink (input valid, cap_voltage_mv, charge_request, referee_power_w,
                path_request, output ready);
endinterface

interface sccp_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  cap_state;
  logic [sccp_pkg::CUR_W-1:0]  charge_current_ma;
  logic                        buck_enable;
  logic                        cap_switch_enable;

  modport source (output valid, cap_state, charge_current_ma, buck_enable,
                  cap_switch_enable, input ready);
  modport sink (input valid, cap_state, charge_current_ma, buck_enable,
                cap_switch_enable, output ready);
endinterface

[sv/supercap_charge_and_path_control.sv]
// Top level: microcoded supercap charge and power path controller.
//
// One beat on in_ch is one control tick; it yields one beat on out_ch with the
// capacitor mode, charger setpoint, buck enable and path switch after the update.
// A six-step control program sequences a small datapath. A tick passes through
// accept, evaluate and emit when no division is needed (charging stopped or left
// as is, or the voltage at or below 12 V or at or above 26.5 V), and also through
// divider init, step and finish when the setpoint is 0.7 * P / V: the restoring
// divider produces one quotient bit per cycle. The result beat is offered from
// the output register once the emit step has run, so the next beat is taken
// while it waits; a second result waits in the emit step until the first has
// left. Configuration writes take effect at the next edge.
module supercap_charge_and_path_control #(
  parameter int VOLTAGE_BITS = sccp_pkg::VOLTAGE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  sccp_in_if.sink                           in_ch,
  sccp_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [sccp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sccp_pkg::CFG_W-1:0]        cfg_data
);

  // Internal signed voltage width: covers the field and the 15 bit thresholds
  localparam int XW = ((VOLTAGE_BITS > 16) ? VOLTAGE_BITS : 16) + 1;
  localparam logic signed [XW-1:0] V_LOW  = XW'(sccp_pkg::V_LOW_MV);
  localparam logic signed [XW-1:0] V_MID  = XW'(sccp_pkg::V_MID_MV);
  localparam logic signed [XW-1:0] V_HIGH = XW'(sccp_pkg::V_HIGH_MV);
  localparam logic [sccp_pkg::Q_W-1:0] Q_DEAD = sccp_pkg::Q_W'(sccp_pkg::DEAD_MA);
  localparam logic [sccp_pkg::Q_W-1:0] Q_MAX  = sccp_pkg::Q_W'(sccp_pkg::CUR_MAX);

  // Configuration registers
  logic [sccp_pkg::CFG_W-1:0] min_v_r, avail_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_v_r   <= sccp_pkg::MIN_VOLTAGE_RST;
      avail_v_r <= sccp_pkg::AVAIL_VOLTAGE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sccp_pkg::CFG_MIN_VOLTAGE:   min_v_r   <= cfg_data;
        sccp_pkg::CFG_AVAIL_VOLTAGE: avail_v_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer
  logic [sccp_pkg::PC_W-1:0] pc_r, pc_nxt;
  sccp_pkg::ctrl_t           cw;
  logic                      wait_hit, jmp_hit, go;

  // Latched tick
  logic signed [VOLTAGE_BITS-1:0] v_r;
  logic [1:0]                     creq_r, preq_r;
  logic [7:0]                     pwr_r;

  // Controller state
  logic [1:0]                 mode_r;
  logic [sccp_pkg::CUR_W-1:0] sp_r;
  logic                       buck_r, sw_r, sw_nxt;

  // Divider
  logic [sccp_pkg::NUM_W-1:0] num_r;
  logic [sccp_pkg::DEN_W-1:0] rem_r;
  logic [sccp_pkg::Q_W-1:0]   dvd_r;
  logic [3:0]                 cnt_r;
  logic [sccp_pkg::DEN_W:0]   trial;
  logic [sccp_pkg::DEN_W:0]   trial_sub;

  // Output register
  logic                       out_valid_r, out_busy;
  logic [1:0]                 out_mode_r;
  logic [sccp_pkg::CUR_W-1:0] out_cur_r;
  logic                       out_buck_r, out_sw_r;

  // Voltage decode
  logic signed [XW-1:0] v_x, min_x, avail_x;
  logic                 need_div;

  assign v_x     = XW'(v_r);
  assign min_x   = $signed({{(XW-sccp_pkg::CFG_W){1'b0}}, min_v_r});
  assign avail_x = $signed({{(XW-sccp_pkg::CFG_W){1'b0}}, avail_v_r});
  assign need_div = (creq_r == sccp_pkg::CHG_RUN) && (v_x > V_MID) && (v_x < V_HIGH);

  assign out_busy = out_valid_r && !out_ch.ready;

  // Condition evaluation
  function automatic logic cond_eval(input sccp_pkg::cond_t c, input logic no_in,
                                     input logic no_div, input logic div_more,
                                     input logic busy);
    logic r;
    unique case (c)
      sccp_pkg::C_NEVER:    r = 1'b0;
      sccp_pkg::C_NO_IN:    r = no_in;
      sccp_pkg::C_NO_DIV:   r = no_div;
      sccp_pkg::C_DIV_MORE: r = div_more;
      sccp_pkg::C_OUT_BUSY: r = busy;
      sccp_pkg::C_ALWAYS:   r = 1'b1;
      default:              r = 1'b0;
    endcase
    return r;
  endfunction

  always_comb begin
    cw       = sccp_pkg::ucode(pc_r);
    wait_hit = cond_eval(cw.wait_c, !in_ch.valid, !need_div, cnt_r != 4'd1, out_busy);
    jmp_hit  = cond_eval(cw.jmp_c, !in_ch.valid, !need_div, cnt_r != 4'd1, out_busy);
    go       = !wait_hit;
    if (wait_hit) begin
      pc_nxt = pc_r;
    end else if (jmp_hit) begin
      pc_nxt = cw.target;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= sccp_pkg::PC_ACCEPT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign in_ch.ready = (pc_r == sccp_pkg::PC_ACCEPT);

  // Input latch
  always_ff @(posedge clk) begin
    if (cw.latch && go) begin
      v_r    <= in_ch.cap_voltage_mv;
      creq_r <= in_ch.charge_request;
      pwr_r  <= in_ch.referee_power_w;
      preq_r <= in_ch.path_request;
    end
  end

  // Numerator product, registered for the divider
  always_ff @(posedge clk) begin
    if (cw.upd_chg && go) begin
      num_r <= sccp_pkg::NUM_W'(sccp_pkg::PWR_K) * sccp_pkg::NUM_W'(pwr_r);
    end
  end

  // Divider datapath: one quotient bit per step
  assign trial     = {rem_r, dvd_r[sccp_pkg::Q_W-1]};
  assign trial_sub = trial - {1'b0, v_x[sccp_pkg::DEN_W-1:0]};

  always_ff @(posedge clk) begin
    if (cw.div_init && go) begin
      rem_r <= sccp_pkg::DEN_W'(num_r[sccp_pkg::NUM_W-1:sccp_pkg::Q_W]);
      dvd_r <= num_r[sccp_pkg::Q_W-1:0];
      cnt_r <= 4'(sccp_pkg::Q_W);
    end else if (cw.div_step && go) begin
      if (trial >= {1'b0, v_x[sccp_pkg::DEN_W-1:0]}) begin
        rem_r <= trial_sub[sccp_pkg::DEN_W-1:0];
        dvd_r <= {dvd_r[sccp_pkg::Q_W-2:0], 1'b1};
      end else begin
        rem_r <= trial[sccp_pkg::DEN_W-1:0];
        dvd_r <= {dvd_r[sccp_pkg::Q_W-2:0], 1'b0};
      end
      cnt_r <= cnt_r - 4'd1;
    end
  end

  // Mode, charger and path state
  always_comb begin
    sw_nxt = sw_r;
    unique case (preq_r)
      sccp_pkg::PATH_CAP: sw_nxt = (mode_r == sccp_pkg::MODE_ON);
      sccp_pkg::PATH_REF: sw_nxt = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= sccp_pkg::MODE_OFF;
      sp_r   <= '0;
      buck_r <= 1'b0;
      sw_r   <= 1'b0;
    end else begin
      // hysteresis on the capacitor mode
      if (cw.upd_mode && go) begin
        priority if (v_x >= 0 && v_x < min_x) begin
          mode_r <= sccp_pkg::MODE_OFF;
        end else if (v_x <= 0) begin
          mode_r <= sccp_pkg::MODE_ERR;
        end else if (v_x >= avail_x) begin
          mode_r <= sccp_pkg::MODE_ON;
        end else begin
          // between the thresholds the mode holds
        end
      end
      // charger request, table part of the setpoint
      if (cw.upd_chg && go) begin
        unique case (creq_r)
          sccp_pkg::CHG_STOP: begin
            buck_r <= 1'b0;
            sp_r   <= '0;
          end
          sccp_pkg::CHG_RUN: begin
            buck_r <= 1'b1;
            priority if (v_x <= V_LOW) begin
              sp_r <= sccp_pkg::CUR_LOW_V;
            end else if (v_x <= V_MID) begin
              sp_r <= sccp_pkg::CUR_MID_V;
            end else if (v_x >= V_HIGH) begin
              sp_r <= '0;
            end else begin
              // divider range: setpoint written by the finish step
            end
          end
          default: ;
        endcase
      end
      // dead zone and clamp on the quotient
      if (cw.div_fin && go) begin
        priority if (dvd_r >= Q_MAX) begin
          sp_r <= sccp_pkg::CUR_MAX;
        end else if (dvd_r < Q_DEAD || (dvd_r == Q_DEAD && rem_r == '0)) begin
          sp_r <= '0;
        end else begin
          sp_r <= dvd_r[sccp_pkg::CUR_W-1:0];
        end
      end
      if (cw.emit && go) begin
        sw_r <= sw_nxt;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cw.emit && go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cw.emit && go) begin
      out_mode_r <= mode_r;
      out_cur_r  <= sp_r;
      out_buck_r <= buck_r;
      out_sw_r   <= sw_nxt;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.cap_state         = out_mode_r;
  assign out_ch.charge_current_ma = out_cur_r;
  assign out_ch.buck_enable       = out_buck_r;
  assign out_ch.cap_switch_enable = out_sw_r;

endmodule

[sv/sccp_checker.sv]
// Checker on the result port of the supercap controller, with its bind.
module sccp_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [1:0]                 cap_state,
  input logic [sccp_pkg::CUR_W-1:0] charge_current_ma,
  input logic                       buck_enable,
  input logic                       cap_switch_enable
);

  // a stalled beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // setpoint never above the clamp
  a_cur_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> charge_current_ma <= sccp_pkg::CUR_MAX)
    else $error("charge setpoint above clamp");

  // a stalled beat keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable({cap_state, charge_current_ma, buck_enable, cap_switch_enable}))
    else $error("result payload changed while stalled");

  // nonzero setpoint only with the buck running
  a_cur_buck: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && charge_current_ma != '0 |-> buck_enable)
    else $error("setpoint nonzero with buck off");

  // mode code is one of the three defined
  a_mode_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cap_state == sccp_pkg::MODE_OFF || cap_state == sccp_pkg::MODE_ON ||
                  cap_state == sccp_pkg::MODE_ERR)
    else $error("undefined capacitor mode code");

endmodule

bind supercap_charge_and_path_control sccp_checker u_sccp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .cap_state         (out_ch.cap_state),
  .charge_current_ma (out_ch.charge_current_ma),
  .buck_enable       (out_ch.buck_enable),
  .cap_switch_enable (out_ch.cap_switch_enable)
);

[tb/sv/supercap_charge_and_path_control_tb.sv]
// Self-checking testbench for the supercap charge and path controller.
`timescale 1ns / 1ps

module supercap_charge_and_path_control_tb;

  localparam int VBITS = sccp_pkg::VOLTAGE_BITS_DEF;
  localparam int RESET_CYCLES = 9;
  localparam int SETTLE_CYCLES = 40;
  localparam int TICKS_PER_PHASE = 105;
  localparam int NUM_PHASES = 7;
  localparam int PRESSURE_AT = 150;       // results seen before the long hold-off
  localparam int HOLD_CYCLES = 300;

  // Request codes and config indexes with no package name
  localparam logic [1:0] CHG_KEEP = 2'd2;
  localparam logic [1:0] CHG_RSVD = 2'd3;
  localparam logic [1:0] PATH_KEEP = 2'd2;
  localparam logic [1:0] PATH_RSVD = 2'd3;
  localparam logic [sccp_pkg::CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [sccp_pkg::CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic [VBITS-1:0] volt;
    logic [1:0]       creq;
    logic [7:0]       power;
    logic [1:0]       preq;
  } tick_t;

  typedef struct packed {
    logic [1:0]                 mode;
    logic [sccp_pkg::CUR_W-1:0] current;
    logic                       buck;
    logic                       sw;
  } status_t;

  // Scoreboard: tracks controller state and the queue of results still owed
  class ctrl_scoreboard;
    logic [sccp_pkg::CFG_W-1:0] min_mv;
    logic [sccp_pkg::CFG_W-1:0] avail_mv;
    status_t                    state;
    status_t                    status_due[$];
    int                         errors;

    function new();
      min_mv = sccp_pkg::MIN_VOLTAGE_RST;
      avail_mv = sccp_pkg::AVAIL_VOLTAGE_RST;
      state = '0;
      errors = 0;
    endfunction

    function void set_cfg(logic [sccp_pkg::CFG_IDX_W-1:0] idx,
                          logic [sccp_pkg::CFG_W-1:0] data);
      if (idx == sccp_pkg::CFG_MIN_VOLTAGE) begin
        min_mv = data;
      end else if (idx == sccp_pkg::CFG_AVAIL_VOLTAGE) begin
        avail_mv = data;
      end
    endfunction

    function int pending();
      return status_due.size();
    endfunction

    // 0.7 * P / V with breakpoints, dead zone and clamp
    function logic [sccp_pkg::CUR_W-1:0] charge_setpoint(longint v, longint p);
      longint num;
      num = 700000 * p;
      if (v <= sccp_pkg::V_LOW_MV) return sccp_pkg::CUR_LOW_V;
      if (v <= sccp_pkg::V_MID_MV) return sccp_pkg::CUR_MID_V;
      if (v >= sccp_pkg::V_HIGH_MV) return '0;
      if (num <= sccp_pkg::DEAD_MA * v) return '0;
      if (num >= longint'(sccp_pkg::CUR_MAX) * v) return sccp_pkg::CUR_MAX;
      return sccp_pkg::CUR_W'(num / v);
    endfunction

    function status_t next_status(tick_t t);
      longint v;
      v = longint'($signed(t.volt));
      // mode with hysteresis
      if (v >= 0 && v < longint'(min_mv)) begin
        state.mode = sccp_pkg::MODE_OFF;
      end else if (v <= 0) begin
        state.mode = sccp_pkg::MODE_ERR;
      end else if (v >= longint'(avail_mv)) begin
        state.mode = sccp_pkg::MODE_ON;
      end
      // charger
      case (t.creq)
        sccp_pkg::CHG_STOP: begin
          state.buck = 1'b0;
          state.current = '0;
        end
        sccp_pkg::CHG_RUN: begin
          state.current = charge_setpoint(v, longint'(t.power));
          state.buck = 1'b1;
        end
        default: ;
      endcase
      // output path uses the mode just updated
      case (t.preq)
        sccp_pkg::PATH_CAP: state.sw = (state.mode == sccp_pkg::MODE_ON);
        sccp_pkg::PATH_REF: state.sw = 1'b0;
        default: ;
      endcase
      return state;
    endfunction

    task report(string msg);
      if (errors < 100) $display("ERROR @%0t: %s", $realtime, msg);
      errors++;
    endtask

    function void note_tick(tick_t t);
      status_due.push_back(next_status(t));
    endfunction

    task check_result(status_t got);
      status_t want;
      if (status_due.size() == 0) begin
        report("result beat with nothing expected");
        return;
      end
      want = status_due.pop_front();
      if (got.mode !== want.mode)
        report($sformatf("cap_state got %0d want %0d", got.mode, want.mode));
      if (got.current !== want.current)
        report($sformatf("charge_current_ma got %0d want %0d", got.current, want.current));
      if (got.buck !== want.buck)
        report($sformatf("buck_enable got %0b want %0b", got.buck, want.buck));
      if (got.sw !== want.sw)
        report($sformatf("cap_switch_enable got %0b want %0b", got.sw, want.sw));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [sccp_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [sccp_pkg::CFG_W-1:0] cfg_data;

  ctrl_scoreboard sb;
  int results_seen = 0;
  bit steady_feed = 1'b0;
  bit pressure_done = 1'b0;

  sccp_in_if #(.VOLTAGE_BITS(VBITS)) in_ch();
  sccp_out_if out_ch();

  supercap_charge_and_path_control #(.VOLTAGE_BITS(VBITS)) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // Idle length: mostly none or short, a few long
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic tick_t make_tick(int v, logic [1:0] creq, int p, logic [1:0] preq);
    tick_t t;
    t.volt = VBITS'(v);
    t.creq = creq;
    t.power = 8'(p);
    t.preq = preq;
    return t;
  endfunction

  // Random tick, biased toward breakpoints and the divider range
  function automatic tick_t random_tick();
    tick_t t;
    int sel;
    int base;
    int r;
    sel = $urandom_range(0, 9);
    if (sel < 2) begin
      t.volt = VBITS'($urandom);
    end else if (sel < 5) begin
      case ($urandom_range(0, 5))
        0: base = 0;
        1: base = int'(sb.min_mv);
        2: base = int'(sb.avail_mv);
        3: base = sccp_pkg::V_LOW_MV;
        4: base = sccp_pkg::V_MID_MV;
        default: base = sccp_pkg::V_HIGH_MV;
      endcase
      t.volt = VBITS'(base + $urandom_range(0, 4) - 2);
    end else begin
      t.volt = VBITS'($urandom_range(0, 30000));
    end
    r = $urandom_range(0, 99);
    if (r < 50) t.creq = sccp_pkg::CHG_RUN;
    else if (r < 70) t.creq = sccp_pkg::CHG_STOP;
    else if (r < 90) t.creq = CHG_KEEP;
    else t.creq = CHG_RSVD;
    r = $urandom_range(0, 99);
    if (r < 45) t.preq = sccp_pkg::PATH_CAP;
    else if (r < 70) t.preq = sccp_pkg::PATH_REF;
    else if (r < 90) t.preq = PATH_KEEP;
    else t.preq = PATH_RSVD;
    t.power = 8'($urandom_range(0, 255));
    return t;
  endfunction

  // Offer one tick and hold it until the block takes it
  task send_tick(tick_t t);
    int gap;
    gap = steady_feed ? 0 : idle_cycles();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cap_voltage_mv <= t.volt;
    in_ch.charge_request <= t.creq;
    in_ch.referee_power_w <= t.power;
    in_ch.path_request <= t.preq;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // One register write, then the enable is driven low again
  task cfg_write(logic [sccp_pkg::CFG_IDX_W-1:0] idx, logic [sccp_pkg::CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_cfg(idx, data);
    @(posedge clk);
  endtask

  // Stop offering, let every owed result arrive, then let the block settle
  task drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task run_directed();
    // mode thresholds and sign
    send_tick(make_tick(0, sccp_pkg::CHG_RUN, 0, sccp_pkg::PATH_CAP));
    send_tick(make_tick(-1, sccp_pkg::CHG_RUN, 255, sccp_pkg::PATH_CAP));
    send_tick(make_tick(-32768, sccp_pkg::CHG_RUN, 255, sccp_pkg::PATH_CAP));
    send_tick(make_tick(32767, sccp_pkg::CHG_RUN, 255, sccp_pkg::PATH_CAP));
    send_tick(make_tick(10000, sccp_pkg::CHG_RUN, 10, sccp_pkg::PATH_CAP)); // mode holds on
    send_tick(make_tick(7999, CHG_KEEP, 10, sccp_pkg::PATH_CAP));           // just below min
    send_tick(make_tick(8000, sccp_pkg::CHG_RUN, 10, sccp_pkg::PATH_CAP));  // at min, holds off
    send_tick(make_tick(11999, sccp_pkg::CHG_RUN, 10, sccp_pkg::PATH_CAP));
    send_tick(make_tick(12000, sccp_pkg::CHG_RUN, 10, sccp_pkg::PATH_CAP)); // at available
    // setpoint breakpoints
    send_tick(make_tick(7000, sccp_pkg::CHG_RUN, 80, PATH_KEEP));
    send_tick(make_tick(7001, sccp_pkg::CHG_RUN, 80, PATH_KEEP));
    send_tick(make_tick(12001, sccp_pkg::CHG_RUN, 255, sccp_pkg::PATH_CAP)); // clamps at 5 A
    send_tick(make_tick(26499, sccp_pkg::CHG_RUN, 1, sccp_pkg::PATH_CAP));   // dead zone
    send_tick(make_tick(26500, sccp_pkg::CHG_RUN, 255, sccp_pkg::PATH_CAP));
    send_tick(make_tick(20000, sccp_pkg::CHG_RUN, 100, sccp_pkg::PATH_CAP)); // exact 3500
    send_tick(make_tick(14000, sccp_pkg::CHG_RUN, 2, sccp_pkg::PATH_CAP));   // quotient exactly 100 mA, dead zone
    send_tick(make_tick(13999, sccp_pkg::CHG_RUN, 2, sccp_pkg::PATH_CAP));   // above dead zone
    send_tick(make_tick(21000, sccp_pkg::CHG_RUN, 150, sccp_pkg::PATH_CAP)); // exactly 5000 mA
    send_tick(make_tick(21001, sccp_pkg::CHG_RUN, 150, sccp_pkg::PATH_CAP));
    // request codes
    send_tick(make_tick(15000, CHG_RSVD, 0, PATH_RSVD));
    send_tick(make_tick(15000, sccp_pkg::CHG_STOP, 0, sccp_pkg::PATH_REF));
    send_tick(make_tick(15000, CHG_RSVD, 200, sccp_pkg::PATH_CAP));
    send_tick(make_tick(16'sh5555, sccp_pkg::CHG_RUN, 8'h55, PATH_KEEP));
    send_tick(make_tick(16'shAAAA, sccp_pkg::CHG_RUN, 8'hAA, sccp_pkg::PATH_CAP));
  endtask

  // Result side: random ready with one long hold-off to back up the block
  initial begin
    int stall;
    int burst;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (!pressure_done && results_seen >= PRESSURE_AT) begin
        pressure_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 100) : $urandom_range(1, 8);
      out_ch.ready <= 1'b1;
      repeat (burst) @(posedge clk);
      stall = idle_cycles();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Beat monitors
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      sb.note_tick(make_tick(int'($signed(in_ch.cap_voltage_mv)), in_ch.charge_request,
                             int'(in_ch.referee_power_w), in_ch.path_request));
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_result('{mode: out_ch.cap_state, current: out_ch.charge_current_ma,
                        buck: out_ch.buck_enable, sw: out_ch.cap_switch_enable});
      results_seen++;
    end
  end

  // Main sequence
  initial begin
    sb = new();
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.cap_voltage_mv <= '0;
    in_ch.charge_request <= sccp_pkg::CHG_STOP;
    in_ch.referee_power_w <= '0;
    in_ch.path_request <= sccp_pkg::PATH_REF;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      steady_feed = (ph == 3);
      case (ph)
        0: run_directed();                     // reset thresholds
        1: begin
          cfg_write(sccp_pkg::CFG_MIN_VOLTAGE, '0);
          cfg_write(sccp_pkg::CFG_AVAIL_VOLTAGE, '0);
        end
        2: begin
          cfg_write(sccp_pkg::CFG_MIN_VOLTAGE, '1);
          cfg_write(sccp_pkg::CFG_AVAIL_VOLTAGE, '1);
          // spare indexes must not disturb the thresholds
          cfg_write(CFG_SPARE_2, sccp_pkg::CFG_W'($urandom));
          cfg_write(CFG_SPARE_3, sccp_pkg::CFG_W'($urandom));
        end
        3: begin                               // min above available
          cfg_write(sccp_pkg::CFG_MIN_VOLTAGE, 15'd20000);
          cfg_write(sccp_pkg::CFG_AVAIL_VOLTAGE, 15'd5000);
        end
        4: begin
          cfg_write(sccp_pkg::CFG_MIN_VOLTAGE, '0);
          cfg_write(sccp_pkg::CFG_AVAIL_VOLTAGE, '1);
        end
        default: begin
          cfg_write(sccp_pkg::CFG_MIN_VOLTAGE, sccp_pkg::CFG_W'($urandom));
          cfg_write(sccp_pkg::CFG_AVAIL_VOLTAGE, sccp_pkg::CFG_W'($urandom));
        end
      endcase
      repeat (TICKS_PER_PHASE) send_tick(random_tick());
      drain();
    end

    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

[files.f]
sv/sccp_pkg.sv
sv/sccp_if.sv
sv/supercap_charge_and_path_control.sv
sv/sccp_checker.sv
tb/sv/supercap_charge_and_path_control_tb.sv
